// ===== rtl/assert_macros.svh =====
// assertion macros, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, pre, post)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/arm_pkg.sv =====
package arm_pkg;

  localparam int VALUE_WIDTH = 48;
  localparam int TIME_WIDTH  = 48;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 2);

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FEW       = 2'd1;
  localparam status_t ST_SOON      = 2'd2;
  localparam status_t ST_ZERO_SPAN = 2'd3;

  localparam logic REG_MODE         = 1'b0;
  localparam logic REG_MIN_INTERVAL = 1'b1;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_RATE  = 1'b1;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

endpackage

// ===== rtl/accumulating_rate_meter.sv =====
// accumulating rate meter
// in channel (in_valid/in_ready) carries kind, value and time_now; out channel
// (out_valid/out_ready) carries result_value and status, one result per item.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes mode (index 0)
// or min_interval (index 1); cfg_ready is always high. a mode write clears the
// totals and samples. write configuration only while the block is idle.
// mode 0 adds each update to a saturating total; mode 1 keeps the two newest
// samples spaced at least min_interval apart, and a query divides the value
// difference by the time span.
// an item is taken in the idle state and goes to the exec state, which writes
// its result to the output register; a rate query with two samples and a
// nonzero span first runs the restoring divider, one quotient bit per cycle,
// before it goes to the exec state.
// in_ready is low while an item is at work.
// the output register frees the input side: the next item is accepted while a
// result waits; a finished item holds in the exec state until the output
// register is empty or taken.
// rst (synchronous) clears mode, min_interval, all samples and the total, and
// drops any pending result.
module accumulating_rate_meter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic signed [arm_pkg::VALUE_WIDTH-1:0] value,
  input  logic        [arm_pkg::TIME_WIDTH-1:0]  time_now,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [arm_pkg::VALUE_WIDTH-1:0] result_value,
  output logic        [1:0]                     status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic        [arm_pkg::TIME_WIDTH-1:0]  cfg_data
);
  import arm_pkg::*;

  `include "assert_macros.svh"

  localparam int VW = VALUE_WIDTH;
  localparam int TW = TIME_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EXEC} state_t;

  state_t state;

  logic                   mode;
  logic [TW-1:0]          min_interval;
  logic signed [VW-1:0]   running_total;
  logic signed [VW-1:0]   newest_sample;
  logic signed [VW-1:0]   older_sample;
  logic [TW-1:0]          newest_time;
  logic [TW-1:0]          older_time;
  logic [1:0]             sample_count;

  logic                   item_kind;
  logic signed [VW-1:0]   item_value;
  logic [TW-1:0]          item_time;

  logic [TW-1:0]          divisor;
  logic [TW-1:0]          rem;
  logic [VW:0]            quo;
  logic                   quo_neg;
  logic [CNT_WIDTH-1:0]   div_count;

  logic [TW-1:0]          span;
  logic                   diff_neg;
  logic [VW:0]            mag;
  logic [TW:0]            trial;
  logic                   trial_ge;
  logic [TW:0]            trial_diff;

  logic [VW:0]            sum;
  logic signed [VW-1:0]   sat_total;
  logic [TW-1:0]          elapsed;
  logic signed [VW-1:0]   rate_res;
  logic signed [VW-1:0]   res_c;
  status_t                st_c;
  logic                   out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // operands for the rate division
  always_comb begin
    span     = newest_time - older_time;
    diff_neg = newest_sample < older_sample;
    if (diff_neg) begin
      mag = {older_sample[VW-1], older_sample} - {newest_sample[VW-1], newest_sample};
    end else begin
      mag = {newest_sample[VW-1], newest_sample} - {older_sample[VW-1], older_sample};
    end
  end

  // restoring divider step
  always_comb begin
    trial      = {rem, quo[VW]};
    trial_ge   = trial >= {1'b0, divisor};
    trial_diff = trial - {1'b0, divisor};
  end

  // result of the latched item
  always_comb begin
    sum = {running_total[VW-1], running_total} + {item_value[VW-1], item_value};
    if (sum[VW] != sum[VW-1]) begin
      sat_total = sum[VW] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_total = sum[VW-1:0];
    end
    elapsed = item_time - newest_time;
    if (quo_neg) begin
      if (quo > {2'b01, {(VW-1){1'b0}}}) begin
        rate_res = VAL_MIN;
      end else begin
        rate_res = -$signed(quo[VW-1:0]);
      end
    end else begin
      if (quo > {2'b00, {(VW-1){1'b1}}}) begin
        rate_res = VAL_MAX;
      end else begin
        rate_res = quo[VW-1:0];
      end
    end
    res_c = '0;
    st_c  = ST_OK;
    unique case ({mode, item_kind})
      {MODE_ACCUM, KIND_UPDATE}: res_c = sat_total;
      {MODE_ACCUM, KIND_QUERY}: begin
        if (sample_count == 2'd0) begin
          st_c = ST_FEW;
        end else begin
          res_c = running_total;
        end
      end
      {MODE_RATE, KIND_UPDATE}: begin
        if (elapsed < min_interval) begin
          st_c = ST_SOON;
        end
      end
      default: begin
        if (sample_count < 2'd2) begin
          st_c = ST_FEW;
        end else if (span == '0) begin
          st_c = ST_ZERO_SPAN;
        end else begin
          res_c = rate_res;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      mode          <= MODE_ACCUM;
      min_interval  <= '0;
      running_total <= '0;
      newest_sample <= '0;
      older_sample  <= '0;
      newest_time   <= '0;
      older_time    <= '0;
      sample_count  <= 2'd0;
      div_count     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) begin
          mode          <= cfg_data[0];
          running_total <= '0;
          newest_sample <= '0;
          older_sample  <= '0;
          newest_time   <= '0;
          older_time    <= '0;
          sample_count  <= 2'd0;
        end else begin
          min_interval <= cfg_data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_kind  <= kind;
            item_value <= value;
            item_time  <= time_now;
            divisor    <= span;
            rem        <= '0;
            quo        <= mag;
            quo_neg    <= diff_neg;
            div_count  <= CNT_WIDTH'(VW);
            if (mode == MODE_RATE && kind == KIND_QUERY && sample_count == 2'd2 &&
                span != '0) begin
              state <= S_DIV;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_DIV: begin
          rem <= trial_ge ? trial_diff[TW-1:0] : trial[TW-1:0];
          quo <= {quo[VW-1:0], trial_ge};
          if (div_count == '0) begin
            state <= S_EXEC;
          end else begin
            div_count <= div_count - 1'b1;
          end
        end
        default: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            result_value <= res_c;
            status       <= st_c;
            state        <= S_IDLE;
            if (mode == MODE_ACCUM && item_kind == KIND_UPDATE) begin
              running_total <= sat_total;
              if (sample_count == 2'd0) begin
                sample_count <= 2'd1;
              end
            end
            if (mode == MODE_RATE && item_kind == KIND_UPDATE && st_c == ST_OK) begin
              older_sample  <= newest_sample;
              older_time    <= newest_time;
              newest_sample <= item_value;
              newest_time   <= item_time;
              if (sample_count < 2'd2) begin
                sample_count <= sample_count + 2'd1;
              end
            end
          end
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_err_zero, out_valid && status != ST_OK, result_value == '0)
  `ASSERT_ALWAYS(a_count_range, sample_count != 2'd3)
  `ASSERT_NEXT(a_div_end, state == S_DIV && div_count == '0, state == S_EXEC)
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import arm_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 60;
  localparam int SEG_ITEMS    = 155;
  localparam int PLAN_LEN     = 31;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] val;
    status_t                       st;
  } meter_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_SET_MODE, ROW_SET_GAP} row_op_t;

  typedef struct packed {
    row_op_t                       op;
    logic                          k;
    logic signed [VALUE_WIDTH-1:0] v;
    logic [TIME_WIDTH-1:0]         t;
    logic                          pinned;
    logic signed [VALUE_WIDTH-1:0] pv;
    status_t                       ps;
  } stim_row_t;

  localparam logic [TIME_WIDTH-1:0] TIME_ALL = {TIME_WIDTH{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = KIND_UPDATE;
  logic signed [VALUE_WIDTH-1:0] value = '0;
  logic [TIME_WIDTH-1:0] time_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VALUE_WIDTH-1:0] result_value;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_MODE;
  logic [TIME_WIDTH-1:0] cfg_data = '0;

  logic pin_use = 1'b0;
  meter_result_t pin_res = '0;

  // predictor state
  logic meter_mode;
  logic [TIME_WIDTH-1:0] gap_floor;
  logic signed [VALUE_WIDTH-1:0] run_total, new_val, old_val;
  logic [TIME_WIDTH-1:0] new_time, old_time;
  logic [1:0] sample_cnt;

  meter_result_t pending_results[$];
  int errors = 0;
  int items_taken = 0, queries_taken = 0, rate_items = 0, reg_writes = 0, results_checked = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic [TIME_WIDTH-1:0] last_stamp = '0;

  stim_row_t plan [PLAN_LEN] = '{
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, 48'sd0, ST_FEW},
    '{ROW_ITEM, KIND_UPDATE, 48'sd5, 48'd0, 1'b1, 48'sd5, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, VAL_MAX, 48'd0, 1'b1, VAL_MAX, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, VAL_MIN, 48'd0, 1'b1, -48'sd1, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, VAL_MIN, 48'd0, 1'b1, VAL_MIN, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, VAL_MIN, ST_OK},
    '{ROW_SET_MODE, KIND_UPDATE, 48'sd0, 48'(MODE_RATE), 1'b0, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, 48'sd0, ST_FEW},
    '{ROW_ITEM, KIND_UPDATE, 48'sd100, 48'd0, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, 48'sd0, ST_FEW},
    '{ROW_ITEM, KIND_UPDATE, 48'sd200, 48'd0, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, 48'sd0, ST_ZERO_SPAN},
    '{ROW_SET_GAP, KIND_UPDATE, 48'sd0, 48'd10, 1'b0, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, 48'sd300, 48'd5, 1'b1, 48'sd0, ST_SOON},
    '{ROW_ITEM, KIND_UPDATE, 48'sd300, 48'd10, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, 48'sd10, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, VAL_MIN, 48'd20, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b0, 48'sd0, ST_OK},
    '{ROW_SET_GAP, KIND_UPDATE, 48'sd0, TIME_ALL, 1'b0, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, 48'sd1, 48'd19, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, 48'sd2, 48'd21, 1'b1, 48'sd0, ST_SOON},
    '{ROW_SET_GAP, KIND_UPDATE, 48'sd0, 48'd0, 1'b0, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, VAL_MIN, 48'd100, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, VAL_MAX, 48'd101, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, VAL_MAX, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, VAL_MIN, 48'd102, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, VAL_MIN, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, 48'sd0, TIME_ALL, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, 48'sd7, 48'd3, 1'b1, 48'sd0, ST_OK},
    '{ROW_ITEM, KIND_QUERY, 48'sd0, 48'd0, 1'b1, 48'sd1, ST_OK},
    '{ROW_ITEM, KIND_UPDATE, -48'sd7, 48'd7, 1'b1, 48'sd0, ST_OK}
  };

  accumulating_rate_meter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .value        (value),
    .time_now     (time_now),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void clear_meter();
    run_total  = '0;
    new_val    = '0;
    old_val    = '0;
    new_time   = '0;
    old_time   = '0;
    sample_cnt = '0;
  endfunction

  function automatic void meter_write_reg(input logic idx, input logic [TIME_WIDTH-1:0] data);
    if (idx == REG_MODE) begin
      meter_mode = data[0];
      clear_meter();
    end else begin
      gap_floor = data;
    end
  endfunction

  function automatic meter_result_t meter_step(input logic k,
                                               input logic signed [VALUE_WIDTH-1:0] v,
                                               input logic [TIME_WIDTH-1:0] t);
    meter_result_t r;
    logic [VALUE_WIDTH:0] sum, diff, mag, quo;
    logic [TIME_WIDTH-1:0] span, elapsed;
    r.val = '0;
    r.st = ST_OK;
    if (meter_mode == MODE_ACCUM) begin
      if (k == KIND_QUERY) begin
        if (sample_cnt == 2'd0) r.st = ST_FEW;
        else r.val = run_total;
      end else begin
        sum = {run_total[VALUE_WIDTH-1], run_total} + {v[VALUE_WIDTH-1], v};
        if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) run_total = sum[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
        else run_total = sum[VALUE_WIDTH-1:0];
        if (sample_cnt == 2'd0) sample_cnt = 2'd1;
        r.val = run_total;
      end
    end else if (k == KIND_QUERY) begin
      span = new_time - old_time;
      if (sample_cnt < 2'd2) begin
        r.st = ST_FEW;
      end else if (span == '0) begin
        r.st = ST_ZERO_SPAN;
      end else begin
        diff = {new_val[VALUE_WIDTH-1], new_val} - {old_val[VALUE_WIDTH-1], old_val};
        mag = diff[VALUE_WIDTH] ? -diff : diff;
        quo = mag / span;
        if (diff[VALUE_WIDTH]) begin
          if (quo > {1'b0, VAL_MIN}) quo = {1'b0, VAL_MIN};
          r.val = -quo[VALUE_WIDTH-1:0];
        end else begin
          if (quo > {1'b0, VAL_MAX}) quo = {1'b0, VAL_MAX};
          r.val = quo[VALUE_WIDTH-1:0];
        end
      end
    end else begin
      elapsed = t - new_time;
      if (elapsed < gap_floor) begin
        r.st = ST_SOON;
      end else begin
        old_val = new_val;
        old_time = new_time;
        new_val = v;
        new_time = t;
        if (sample_cnt < 2'd2) sample_cnt = sample_cnt + 2'd1;
      end
    end
    return r;
  endfunction

  // scoreboard
  always @(posedge clk) begin
    meter_result_t want, got;
    if (rst) begin
      meter_mode = MODE_ACCUM;
      gap_floor = '0;
      clear_meter();
    end else begin
      if (out_valid && out_ready) begin
        got.val = result_value;
        got.st = status;
        if (pending_results.size() == 0) begin
          errors++;
          $error("result item with none expected: result_value %0d status %0d", got.val, got.st);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.val !== want.val) begin
            errors++;
            $error("result_value: expected %0d, got %0d", want.val, got.val);
          end
          if (got.st !== want.st) begin
            errors++;
            $error("status: expected %0d, got %0d", want.st, got.st);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        meter_write_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        items_taken++;
        if (kind == KIND_QUERY) queries_taken++;
        if (meter_mode == MODE_RATE) rate_items++;
        want = meter_step(kind, value, time_now);
        if (pin_use) want = pin_res;
        pending_results.push_back(want);
      end
    end
  end

  // result side backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic push_item(input logic k, input logic signed [VALUE_WIDTH-1:0] v,
                           input logic [TIME_WIDTH-1:0] t, input logic pinned,
                           input meter_result_t pinned_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cfg_valid <= 1'b0;
    kind <= k;
    value <= v;
    time_now <= t;
    pin_use <= pinned;
    pin_res <= pinned_res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [TIME_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    int s;
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3, 4, 5: begin
        s = int'($urandom_range(2000)) - 1000;
        return VALUE_WIDTH'(s);
      end
      default: return rand48();
    endcase
  endfunction

  function automatic logic [TIME_WIDTH-1:0] pick_stamp(input logic [TIME_WIDTH-1:0] gap);
    logic [TIME_WIDTH-1:0] delta;
    case ($urandom_range(9))
      0: delta = '0;
      1, 2: delta = (gap == '0) ? '0 : rand48() % gap;
      8: delta = rand48();
      default: delta = gap + TIME_WIDTH'($urandom_range(20));
    endcase
    last_stamp = last_stamp + delta;
    return last_stamp;
  endfunction

  task automatic run_segment(input int n_items, input logic hold);
    logic [TIME_WIDTH-1:0] gap;
    logic k;
    case ($urandom_range(3))
      0: gap = '0;
      1: gap = TIME_WIDTH'($urandom_range(1, 40));
      2: gap = rand48();
      default: gap = TIME_ALL;
    endcase
    drain_results();
    if ($urandom_range(3) != 0) write_reg(REG_MODE, 48'($urandom_range(1)));
    write_reg(REG_MIN_INTERVAL, gap);
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      k = ($urandom_range(99) < 30) ? KIND_QUERY : KIND_UPDATE;
      push_item(k, pick_value(), pick_stamp(gap), 1'b0, '0);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 69;

    foreach (plan[i]) begin
      case (plan[i].op)
        ROW_ITEM: begin
          push_item(plan[i].k, plan[i].v, plan[i].t, plan[i].pinned, {plan[i].pv, plan[i].ps});
        end
        ROW_SET_MODE: begin
          drain_results();
          write_reg(REG_MODE, plan[i].t);
        end
        default: begin
          drain_results();
          write_reg(REG_MIN_INTERVAL, plan[i].t);
        end
      endcase
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 20 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        run_segment(SEG_ITEMS, phase == 0 && seg == 1);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $error("%0d expected result items never arrived", pending_results.size());
    end
    $display("covered %0d items (%0d queries, %0d in rate mode) and %0d register writes,",
             items_taken, queries_taken, rate_items, reg_writes);
    $display("with %0d results checked under mixed stalls and one long output hold-off",
             results_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
